@@ hw/rtl/rfb_pkg.sv @@
// Package for the response frame builder: item codes, command struct,
// frame constants and the CRC-16/MODBUS byte update.
// No dependencies.
package rfb_pkg;

   // Input mode codes
   typedef enum logic [1:0] {
      MODE_CONTENT   = 2'd0,
      MODE_OK        = 2'd1,
      MODE_ERROR     = 2'd2,
      MODE_HEARTBEAT = 2'd3
   } mode_type;

   // Register indexes
   localparam logic [1:0] CSR_RESPONSE_TYPE = 2'd0;
   localparam logic [1:0] CSR_FRAME_VERSION = 2'd1;
   localparam logic [1:0] CSR_MAX_FRAME_LEN = 2'd2;

   // Register reset values
   localparam logic [7:0] RESPONSE_TYPE_RST = 8'd1;
   localparam logic [7:0] FRAME_VERSION_RST = 8'd1;
   localparam logic [8:0] MAX_FRAME_LEN_RST = 9'd268;

   // Commands from front to back
   typedef enum logic [1:0] {
      OP_REFUSE = 2'd0,
      OP_FRAME  = 2'd1,
      OP_BYTE   = 2'd2
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] dev;
      logic [7:0]  kind;
      logic [15:0] cmd;
      logic [7:0]  len;
      logic        has_byte;
      logic [7:0]  data;
      logic        has_tail;
   } cmd_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE   = 3'd0,
      BK_REFUSE = 3'd1,
      BK_HEAD   = 3'd2,
      BK_BODY   = 3'd3,
      BK_TAIL   = 3'd4
   } bk_state_type;

   // Frame constants
   localparam logic [7:0]  HDR_BYTE0      = 8'hA5;
   localparam logic [7:0]  HDR_BYTE1      = 8'hB6;
   localparam logic [7:0]  TRL_BYTE0      = 8'hB6;
   localparam logic [7:0]  TRL_BYTE1      = 8'hA5;
   localparam logic [7:0]  ERR_TYPE       = 8'hFF;
   localparam logic [15:0] ERR_CMD        = 16'hEEEE;
   localparam logic [7:0]  HB_TYPE        = 8'h05;
   localparam logic [15:0] HB_CMD         = 16'h8888;
   localparam logic [7:0]  OK_DATA        = 8'hFF;
   localparam logic [9:0]  FRAME_OVERHEAD = 10'd13;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;

   // Step counter for header and trailer
   localparam int          STEP_W    = 4;
   localparam logic [3:0]  HEAD_LAST = 4'd8;
   localparam logic [3:0]  TAIL_LAST = 4'd3;

   // Command queue depth
   localparam int QUEUE_DEPTH = 2;

   // One byte through the reflected CRC-16/MODBUS
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/rfb_front.sv @@
// Front end: accepts request items, tracks open and absorbed frames and
// turns each item into at most one command. Depends on rfb_pkg.
module rfb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_mode,
   input  logic [15:0]      req_device_id,
   input  logic [15:0]      req_cmd_word,
   input  logic [7:0]       req_content_size,
   input  logic [7:0]       req_content_byte,
   input  logic [7:0]       response_type,
   input  logic [8:0]       max_frame_len,
   input  logic             q_ready,
   output logic             q_push,
   output rfb_pkg::cmd_type q_cmd
);

   logic       frame_open_ff, frame_open_in;
   logic       discarding_ff, discarding_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic       accept;
   logic       has_cmd;
   logic       long_size, long_one, long_zero;
   logic [7:0] left_dec;
   rfb_pkg::mode_type mode;

   assign req_ready = q_ready;
   assign accept    = req_valid && req_ready;
   assign mode      = rfb_pkg::mode_type'(req_mode);
   assign left_dec  = (bytes_left_ff != 8'd0) ? bytes_left_ff - 8'd1 : 8'd0;

   // Length checks against the frame limit
   assign long_size = (rfb_pkg::FRAME_OVERHEAD + {2'b00, req_content_size})
                      > {1'b0, max_frame_len};
   assign long_one  = (rfb_pkg::FRAME_OVERHEAD + 10'd1) > {1'b0, max_frame_len};
   assign long_zero = rfb_pkg::FRAME_OVERHEAD > {1'b0, max_frame_len};

   // Classify the item
   always_comb begin
      frame_open_in = frame_open_ff;
      discarding_in = discarding_ff;
      bytes_left_in = bytes_left_ff;
      has_cmd       = 1'b0;
      q_cmd.op       = rfb_pkg::OP_FRAME;
      q_cmd.dev      = req_device_id;
      q_cmd.kind     = response_type;
      q_cmd.cmd      = req_cmd_word;
      q_cmd.len      = req_content_size;
      q_cmd.has_byte = 1'b0;
      q_cmd.data     = req_content_byte;
      q_cmd.has_tail = 1'b1;
      case (mode)
         rfb_pkg::MODE_CONTENT: begin
            if (discarding_ff) begin
               bytes_left_in = left_dec;
               if (left_dec == 8'd0) begin
                  discarding_in = 1'b0;
               end
            end else if (frame_open_ff) begin
               has_cmd        = 1'b1;
               q_cmd.op       = rfb_pkg::OP_BYTE;
               q_cmd.has_byte = 1'b1;
               q_cmd.has_tail = (left_dec == 8'd0);
               bytes_left_in  = left_dec;
               if (left_dec == 8'd0) begin
                  frame_open_in = 1'b0;
               end
            end else if (long_size) begin
               has_cmd  = 1'b1;
               q_cmd.op = rfb_pkg::OP_REFUSE;
               if (req_content_size > 8'd1) begin
                  bytes_left_in = req_content_size - 8'd1;
                  discarding_in = 1'b1;
               end
            end else begin
               has_cmd        = 1'b1;
               q_cmd.has_byte = (req_content_size != 8'd0);
               q_cmd.has_tail = (req_content_size <= 8'd1);
               if (req_content_size > 8'd1) begin
                  bytes_left_in = req_content_size - 8'd1;
                  frame_open_in = 1'b1;
               end
            end
         end
         rfb_pkg::MODE_OK: begin
            frame_open_in  = 1'b0;
            discarding_in  = 1'b0;
            bytes_left_in  = 8'd0;
            has_cmd        = 1'b1;
            q_cmd.op       = long_one ? rfb_pkg::OP_REFUSE : rfb_pkg::OP_FRAME;
            q_cmd.len      = 8'd1;
            q_cmd.has_byte = 1'b1;
            q_cmd.data     = rfb_pkg::OK_DATA;
         end
         rfb_pkg::MODE_ERROR: begin
            frame_open_in = 1'b0;
            discarding_in = 1'b0;
            bytes_left_in = 8'd0;
            has_cmd       = 1'b1;
            q_cmd.op      = long_zero ? rfb_pkg::OP_REFUSE : rfb_pkg::OP_FRAME;
            q_cmd.kind    = rfb_pkg::ERR_TYPE;
            q_cmd.cmd     = rfb_pkg::ERR_CMD;
            q_cmd.len     = 8'd0;
         end
         default: begin
            frame_open_in = 1'b0;
            discarding_in = 1'b0;
            bytes_left_in = 8'd0;
            has_cmd       = 1'b1;
            q_cmd.op      = long_zero ? rfb_pkg::OP_REFUSE : rfb_pkg::OP_FRAME;
            q_cmd.kind    = rfb_pkg::HB_TYPE;
            q_cmd.cmd     = rfb_pkg::HB_CMD;
            q_cmd.len     = 8'd0;
         end
      endcase
   end

   assign q_push = accept && has_cmd;

   // Frame tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         discarding_ff <= 1'b0;
         bytes_left_ff <= 8'd0;
      end else if (accept) begin
         frame_open_ff <= frame_open_in;
         discarding_ff <= discarding_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

@@ hw/rtl/rfb_queue.sv @@
// Short command queue between front and back end, held in flops.
// Depends on rfb_pkg.
module rfb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rfb_pkg::cmd_type push_cmd,
   output logic             not_full,
   input  logic             pop,
   output logic             not_empty,
   output rfb_pkg::cmd_type head_cmd
);

   localparam int PTR_W = (rfb_pkg::QUEUE_DEPTH > 1) ? $clog2(rfb_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(rfb_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(rfb_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(rfb_pkg::QUEUE_DEPTH);

   rfb_pkg::cmd_type  entry_ff [rfb_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign not_full  = (count_ff != CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign head_cmd  = entry_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hw/rtl/rfb_back.sv @@
// Back end: sequencer that serializes one command into frame bytes,
// runs the CRC and drives the response output register. Depends on rfb_pkg.
module rfb_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  rfb_pkg::cmd_type q_cmd,
   output logic             q_pop,
   input  logic [7:0]       frame_version,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_frame_end,
   output logic             rsp_refused
);

   rfb_pkg::bk_state_type       state_ff, state_in;
   logic [rfb_pkg::STEP_W-1:0]  step_ff, step_in;
   rfb_pkg::cmd_type            cmd_ff;
   logic                        cmd_load;
   logic [15:0]                 crc_ff, crc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  byte_ff;
   logic                        end_ff, refused_ff;
   logic                        adv;
   logic [7:0]                  byte_sel;
   logic                        end_sel, refused_sel;
   logic                        crc_en, crc_restart, crc_clear;

   // A byte moves into the output register when it is free or draining
   assign adv = (state_ff != rfb_pkg::BK_IDLE) && (!rsp_valid_ff || rsp_ready);

   // Next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      q_pop    = 1'b0;
      cmd_load = 1'b0;
      case (state_ff)
         rfb_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_load = 1'b1;
               step_in  = '0;
               case (q_cmd.op)
                  rfb_pkg::OP_REFUSE: state_in = rfb_pkg::BK_REFUSE;
                  rfb_pkg::OP_BYTE:   state_in = rfb_pkg::BK_BODY;
                  default:            state_in = rfb_pkg::BK_HEAD;
               endcase
            end
         end
         rfb_pkg::BK_REFUSE: begin
            if (adv) begin
               state_in = rfb_pkg::BK_IDLE;
            end
         end
         rfb_pkg::BK_HEAD: begin
            if (adv) begin
               if (step_ff == rfb_pkg::HEAD_LAST) begin
                  step_in = '0;
                  if (cmd_ff.has_byte) begin
                     state_in = rfb_pkg::BK_BODY;
                  end else if (cmd_ff.has_tail) begin
                     state_in = rfb_pkg::BK_TAIL;
                  end else begin
                     state_in = rfb_pkg::BK_IDLE;
                  end
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         rfb_pkg::BK_BODY: begin
            if (adv) begin
               step_in  = '0;
               state_in = cmd_ff.has_tail ? rfb_pkg::BK_TAIL : rfb_pkg::BK_IDLE;
            end
         end
         rfb_pkg::BK_TAIL: begin
            if (adv) begin
               if (step_ff == rfb_pkg::TAIL_LAST) begin
                  step_in  = '0;
                  state_in = rfb_pkg::BK_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = rfb_pkg::BK_IDLE;
            step_in  = '0;
         end
      endcase
   end

   // Byte selection per state and step
   always_comb begin
      byte_sel    = 8'h00;
      end_sel     = 1'b0;
      refused_sel = 1'b0;
      crc_en      = 1'b0;
      crc_restart = 1'b0;
      crc_clear   = 1'b0;
      case (state_ff)
         rfb_pkg::BK_REFUSE: begin
            end_sel     = 1'b1;
            refused_sel = 1'b1;
         end
         rfb_pkg::BK_HEAD: begin
            crc_en      = 1'b1;
            crc_restart = (step_ff == '0);
            case (step_ff)
               4'd0:    byte_sel = rfb_pkg::HDR_BYTE0;
               4'd1:    byte_sel = rfb_pkg::HDR_BYTE1;
               4'd2:    byte_sel = cmd_ff.dev[15:8];
               4'd3:    byte_sel = cmd_ff.dev[7:0];
               4'd4:    byte_sel = cmd_ff.kind;
               4'd5:    byte_sel = cmd_ff.cmd[15:8];
               4'd6:    byte_sel = cmd_ff.cmd[7:0];
               4'd7:    byte_sel = cmd_ff.len;
               default: byte_sel = frame_version;
            endcase
         end
         rfb_pkg::BK_BODY: begin
            crc_en   = 1'b1;
            byte_sel = cmd_ff.data;
         end
         rfb_pkg::BK_TAIL: begin
            case (step_ff)
               4'd0:    byte_sel = crc_ff[15:8];
               4'd1:    byte_sel = crc_ff[7:0];
               4'd2:    byte_sel = rfb_pkg::TRL_BYTE0;
               default: begin
                  byte_sel  = rfb_pkg::TRL_BYTE1;
                  end_sel   = 1'b1;
                  crc_clear = 1'b1;
               end
            endcase
         end
         default: begin
            byte_sel = 8'h00;
         end
      endcase
   end

   // CRC accumulator
   always_comb begin
      crc_in = crc_ff;
      if (adv) begin
         if (crc_en) begin
            crc_in = rfb_pkg::crc16_byte(crc_restart ? rfb_pkg::CRC_INIT : crc_ff, byte_sel);
         end else if (crc_clear) begin
            crc_in = rfb_pkg::CRC_INIT;
         end
      end
   end

   // Output register valid
   always_comb begin
      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfb_pkg::BK_IDLE;
         step_ff      <= '0;
         crc_ff       <= rfb_pkg::CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd_load) begin
         cmd_ff <= q_cmd;
      end
      if (adv) begin
         byte_ff    <= byte_sel;
         end_ff     <= end_sel;
         refused_ff <= refused_sel;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_frame_end = end_ff;
   assign rsp_refused   = refused_ff;

   // A refusal is a single zero byte that also ends the frame
   a_refuse_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && refused_ff) |-> (end_ff && byte_ff == 8'h00))
      else $error("refusal result malformed");

   // Header step never runs past the version byte
   a_head_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfb_pkg::BK_HEAD) |-> (step_ff <= rfb_pkg::HEAD_LAST))
      else $error("header step out of range");

   // Trailer step never runs past the last trailer byte
   a_tail_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfb_pkg::BK_TAIL) |-> (step_ff <= rfb_pkg::TAIL_LAST))
      else $error("trailer step out of range");

   // A command is taken only in idle, and taking one moves the sequencer out of idle
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff != rfb_pkg::BK_IDLE))
      else $error("command popped without starting");

endmodule

@@ hw/rtl/response_frame_builder_crc16_core.sv @@
// With the back end idle, an item's first result byte passes through the command queue,
// the back-end command register and the output register, then one byte per cycle
// follows while rsp_ready is high.
// The back-end byte sequencer returns to idle between commands, and the 2-entry
// command queue lets input run ahead.
// Reset (synchronous): registers to their defaults, queue empty, CRC FFFF.
module response_frame_builder_crc16_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_device_id,
   input  logic [15:0] req_cmd_word,
   input  logic [7:0]  req_content_size,
   input  logic [7:0]  req_content_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end,
   output logic        rsp_refused,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);

   logic [7:0]       response_type_ff;
   logic [7:0]       frame_version_ff;
   logic [8:0]       max_frame_len_ff;
   logic             q_ready, q_push, q_valid, q_pop;
   rfb_pkg::cmd_type push_cmd, head_cmd;

   // Configuration registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         response_type_ff <= rfb_pkg::RESPONSE_TYPE_RST;
         frame_version_ff <= rfb_pkg::FRAME_VERSION_RST;
         max_frame_len_ff <= rfb_pkg::MAX_FRAME_LEN_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rfb_pkg::CSR_RESPONSE_TYPE: response_type_ff <= csr_wdata[7:0];
            rfb_pkg::CSR_FRAME_VERSION: frame_version_ff <= csr_wdata[7:0];
            rfb_pkg::CSR_MAX_FRAME_LEN: max_frame_len_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   rfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_device_id    (req_device_id),
      .req_cmd_word     (req_cmd_word),
      .req_content_size (req_content_size),
      .req_content_byte (req_content_byte),
      .response_type    (response_type_ff),
      .max_frame_len    (max_frame_len_ff),
      .q_ready          (q_ready),
      .q_push           (q_push),
      .q_cmd            (push_cmd)
   );

   rfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .not_full  (q_ready),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_cmd  (head_cmd)
   );

   rfb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (head_cmd),
      .q_pop         (q_pop),
      .frame_version (frame_version_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end),
      .rsp_refused   (rsp_refused)
   );

endmodule

@@ test/tb.sv @@
// Testbench for response_frame_builder_crc16_core: a directed table, then random frame
// traffic, with every output byte checked against a CRC-16/MODBUS frame predictor.
// Depends on rfb_pkg and the core RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Register index with no register behind it
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   // Extra cycles waited after the last expected byte before a register write
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       refused;
   } frame_byte_type;

   // One row of the directed table: an item or a register write
   typedef struct {
      bit                is_reg;
      rfb_pkg::mode_type mode;
      logic [15:0]       dev;
      logic [15:0]       cmd;
      logic [7:0]        len;
      logic [7:0]        data;
      int                want_count;   // -1: left to the predictor
      bit                want_refused;
      logic [1:0]        reg_index;
      logic [8:0]        reg_value;
   } stim_row_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode         = rfb_pkg::MODE_CONTENT;
   logic [15:0] req_device_id    = '0;
   logic [15:0] req_cmd_word     = '0;
   logic [7:0]  req_content_size = '0;
   logic [7:0]  req_content_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_frame_end;
   logic        rsp_refused;
   logic        csr_valid        = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index        = '0;
   logic [8:0]  csr_wdata        = '0;

   // Predictor state and its copy of the registers
   frame_byte_type frame_bytes_due[$];
   logic [15:0] crc_run      = 16'hFFFF;
   logic [7:0]  content_left = '0;
   logic        frame_active = 1'b0;
   logic        absorbing    = 1'b0;
   logic [7:0]  cfg_type     = 8'd1;
   logic [7:0]  cfg_version  = 8'd1;
   logic [8:0]  cfg_max_len  = 9'd268;

   stim_row_type directed_rows[$];
   int        bad_checks = 0;
   int        items_sent = 0;
   bit        gaps_on    = 1'b1;
   int        stall_left = 0;

   response_frame_builder_crc16_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_device_id    (req_device_id),
      .req_cmd_word     (req_cmd_word),
      .req_content_size (req_content_size),
      .req_content_byte (req_content_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_refused      (rsp_refused),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------- frame predictor ----------------

   function automatic void expect_byte(logic [7:0] b, logic last, logic refused);
      frame_byte_type fb;
      fb.data    = b;
      fb.last    = last;
      fb.refused = refused;
      frame_bytes_due.push_back(fb);
   endfunction

   // Byte covered by the CRC (reflected, poly A001)
   function automatic void expect_crc_byte(logic [7:0] b);
      logic [15:0] c;
      c = crc_run ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      crc_run = c;
      expect_byte(b, 1'b0, 1'b0);
   endfunction

   function automatic void expect_header(logic [15:0] dev, logic [7:0] kind,
                                         logic [15:0] cmd, logic [7:0] len);
      crc_run = 16'hFFFF;
      expect_crc_byte(8'hA5);
      expect_crc_byte(8'hB6);
      expect_crc_byte(dev[15:8]);
      expect_crc_byte(dev[7:0]);
      expect_crc_byte(kind);
      expect_crc_byte(cmd[15:8]);
      expect_crc_byte(cmd[7:0]);
      expect_crc_byte(len);
      expect_crc_byte(cfg_version);
   endfunction

   function automatic void expect_trailer();
      logic [15:0] c;
      c = crc_run;
      expect_byte(c[15:8], 1'b0, 1'b0);
      expect_byte(c[7:0], 1'b0, 1'b0);
      expect_byte(8'hB6, 1'b0, 1'b0);
      expect_byte(8'hA5, 1'b1, 1'b0);
      crc_run = 16'hFFFF;
   endfunction

   function automatic bit over_limit(int len);
      return (13 + len) > int'(cfg_max_len);
   endfunction

   function automatic void predict_frame_bytes(rfb_pkg::mode_type m, logic [15:0] dev, cmd,
                                               logic [7:0] len, data);
      if (m == rfb_pkg::MODE_CONTENT) begin
         if (absorbing) begin
            // refused frame: swallow its remaining content items
            if (content_left != 0) content_left--;
            if (content_left == 0) absorbing = 1'b0;
         end else if (frame_active) begin
            expect_crc_byte(data);
            if (content_left != 0) content_left--;
            if (content_left == 0) begin
               expect_trailer();
               frame_active = 1'b0;
            end
         end else if (over_limit(int'(len))) begin
            expect_byte(8'h00, 1'b1, 1'b1);
            if (len > 1) begin
               content_left = len - 8'd1;
               absorbing    = 1'b1;
            end
         end else begin
            expect_header(dev, cfg_type, cmd, len);
            if (len == 0) begin
               expect_trailer();
            end else begin
               expect_crc_byte(data);
               content_left = len - 8'd1;
               if (content_left == 0) expect_trailer();
               else frame_active = 1'b1;
            end
         end
      end else begin
         // a fixed frame drops any open or absorbed content frame
         frame_active = 1'b0;
         absorbing    = 1'b0;
         content_left = '0;
         if (over_limit((m == rfb_pkg::MODE_OK) ? 1 : 0)) begin
            expect_byte(8'h00, 1'b1, 1'b1);
         end else if (m == rfb_pkg::MODE_OK) begin
            expect_header(dev, cfg_type, cmd, 8'd1);
            expect_crc_byte(8'hFF);
            expect_trailer();
         end else if (m == rfb_pkg::MODE_ERROR) begin
            expect_header(dev, 8'hFF, 16'hEEEE, 8'd0);
            expect_trailer();
         end else begin
            expect_header(dev, 8'h05, 16'h8888, 8'd0);
            expect_trailer();
         end
      end
   endfunction

   function automatic void apply_reg(logic [1:0] idx, logic [8:0] v);
      case (idx)
         rfb_pkg::CSR_RESPONSE_TYPE: cfg_type    = v[7:0];
         rfb_pkg::CSR_FRAME_VERSION: cfg_version = v[7:0];
         rfb_pkg::CSR_MAX_FRAME_LEN: cfg_max_len = v;
         default: ;
      endcase
   endfunction

   // ---------------- drivers ----------------

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_item(input rfb_pkg::mode_type m, input logic [15:0] dev, cmd,
                            input logic [7:0] len, data, output int produced);
      int gap;
      int before_n;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= m;
      req_device_id    <= dev;
      req_cmd_word     <= cmd;
      req_content_size <= len;
      req_content_byte <= data;
      do @(posedge clock); while (!req_ready);
      before_n = frame_bytes_due.size();
      predict_frame_bytes(m, dev, cmd, len, data);
      produced = frame_bytes_due.size() - before_n;
      items_sent++;
   endtask

   // Stop sending and let the core drain completely
   task automatic settle();
      req_valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only with the core idle
   task automatic write_reg(input logic [1:0] idx, input logic [8:0] v);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_reg(idx, v);
   endtask

   // Receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------- output check ----------------

   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_bytes_due.size() == 0) begin
            bad_checks++;
            $display("%0t: unexpected byte: expected none, got %02h end %0b refused %0b",
                     $time, rsp_out_byte, rsp_frame_end, rsp_refused);
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_out_byte !== want.data) begin
               bad_checks++;
               $display("%0t: out_byte expected %02h got %02h", $time, want.data, rsp_out_byte);
            end
            if (rsp_frame_end !== want.last) begin
               bad_checks++;
               $display("%0t: frame_end expected %0b got %0b", $time, want.last, rsp_frame_end);
            end
            if (rsp_refused !== want.refused) begin
               bad_checks++;
               $display("%0t: refused expected %0b got %0b", $time, want.refused, rsp_refused);
            end
         end
      end
   end

   // ---------------- directed table ----------------

   function automatic void add_item(rfb_pkg::mode_type m, logic [15:0] dev, cmd,
                                    logic [7:0] len, data, int want_count,
                                    bit want_refused);
      stim_row_type row;
      row = '{mode: rfb_pkg::MODE_CONTENT, default: '0};
      row.mode         = m;
      row.dev          = dev;
      row.cmd          = cmd;
      row.len          = len;
      row.data         = data;
      row.want_count   = want_count;
      row.want_refused = want_refused;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_reg(logic [1:0] idx, logic [8:0] v);
      stim_row_type row;
      row = '{mode: rfb_pkg::MODE_CONTENT, default: '0};
      row.is_reg    = 1'b1;
      row.reg_index = idx;
      row.reg_value = v;
      directed_rows.push_back(row);
   endfunction

   function automatic void build_directed_rows();
      // fixed frames and the simplest content frames at reset settings
      add_item(rfb_pkg::MODE_HEARTBEAT, 16'h0000, 16'h0000, 8'h00, 8'h00, 13, 1'b0);
      add_item(rfb_pkg::MODE_ERROR,     16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 13, 1'b0);
      add_item(rfb_pkg::MODE_OK,        16'h1234, 16'hFFFF, 8'h00, 8'h00, 14, 1'b0);
      // empty content frame, content byte ignored
      add_item(rfb_pkg::MODE_CONTENT,   16'hFFFF, 16'h0000, 8'h00, 8'hAA, 13, 1'b0);
      add_item(rfb_pkg::MODE_CONTENT,   16'h0000, 16'hFFFF, 8'h01, 8'h00, 14, 1'b0);
      // three-byte frame; later items carry junk in the frame-start fields
      add_item(rfb_pkg::MODE_CONTENT,   16'h8001, 16'h7FFE, 8'h03, 8'hFF, 10, 1'b0);
      add_item(rfb_pkg::MODE_CONTENT,   16'h0000, 16'h0000, 8'h00, 8'h00, 1, 1'b0);
      add_item(rfb_pkg::MODE_CONTENT,   16'hFFFF, 16'hFFFF, 8'hFF, 8'h5A, 5, 1'b0);
      // largest content size exactly fits the reset limit, then a heartbeat abandons it
      add_item(rfb_pkg::MODE_CONTENT,   16'h00FF, 16'hFF00, 8'hFF, 8'hC3, 10, 1'b0);
      add_item(rfb_pkg::MODE_CONTENT,   16'h1111, 16'h2222, 8'h33, 8'h3C, 1, 1'b0);
      add_item(rfb_pkg::MODE_HEARTBEAT, 16'h5555, 16'hAAAA, 8'h0F, 8'hF0, 13, 1'b0);
      // limit of a bare frame: ok refused, refused content frame absorbed
      add_reg(rfb_pkg::CSR_MAX_FRAME_LEN, 9'd13);
      add_item(rfb_pkg::MODE_OK,        16'hA5A5, 16'h5A5A, 8'h00, 8'h00, 1, 1'b1);
      add_item(rfb_pkg::MODE_CONTENT,   16'h0F0F, 16'hF0F0, 8'h00, 8'h77, 13, 1'b0);
      add_item(rfb_pkg::MODE_CONTENT,   16'h0001, 16'h0002, 8'h03, 8'h44, 1, 1'b1);
      add_item(rfb_pkg::MODE_CONTENT,   16'h0003, 16'h0004, 8'h00, 8'h55, 0, 1'b0);
      add_item(rfb_pkg::MODE_CONTENT,   16'h0005, 16'h0006, 8'h00, 8'h66, 0, 1'b0);
      add_item(rfb_pkg::MODE_CONTENT,   16'hBEEF, 16'hCAFE, 8'h00, 8'h00, 13, 1'b0);
      // zero limit: everything refused, an error item ends the absorbing
      add_reg(rfb_pkg::CSR_MAX_FRAME_LEN, 9'd0);
      add_item(rfb_pkg::MODE_HEARTBEAT, 16'h0102, 16'h0304, 8'h00, 8'h00, 1, 1'b1);
      add_item(rfb_pkg::MODE_CONTENT,   16'h0506, 16'h0708, 8'h04, 8'h09, 1, 1'b1);
      add_item(rfb_pkg::MODE_CONTENT,   16'h0A0B, 16'h0C0D, 8'h00, 8'h0E, 0, 1'b0);
      add_item(rfb_pkg::MODE_ERROR,     16'h0F10, 16'h1112, 8'h00, 8'h00, 1, 1'b1);
      // register extremes and a limit above the largest frame
      add_reg(rfb_pkg::CSR_RESPONSE_TYPE, 9'h0FF);
      add_reg(rfb_pkg::CSR_FRAME_VERSION, 9'h100);
      add_reg(rfb_pkg::CSR_MAX_FRAME_LEN, 9'h1FF);
      add_item(rfb_pkg::MODE_CONTENT,   16'h7F7F, 16'h8080, 8'hFF, 8'h81, 10, 1'b0);
      add_item(rfb_pkg::MODE_CONTENT,   16'h0000, 16'h0000, 8'h00, 8'h7E, -1, 1'b0);
      add_item(rfb_pkg::MODE_OK,        16'hFEDC, 16'hBA98, 8'h00, 8'h00, -1, 1'b0);
   endfunction

   // ---------------- random traffic ----------------

   task automatic run_frames(input int target);
      int pick;
      int r;
      int len;
      int n_items;
      int k;
      int produced;
      bit broken;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 58) begin
            // content frame, mostly small, rarely near the largest size
            r = $urandom_range(0, 99);
            if (r < 45) len = $urandom_range(0, 4);
            else if (r < 85) len = $urandom_range(5, 16);
            else if (r < 97) len = $urandom_range(17, 60);
            else len = $urandom_range(200, 255);
            n_items = (len == 0) ? 1 : len;
            broken = ($urandom_range(0, 9) == 0) || (len > 60 && $urandom_range(0, 1) == 0);
            if (broken) n_items = $urandom_range(1, n_items);
            send_item(rfb_pkg::MODE_CONTENT, 16'($urandom), 16'($urandom), len[7:0],
                      8'($urandom), produced);
            for (k = 1; k < n_items && items_sent < target; k++) begin
               send_item(rfb_pkg::MODE_CONTENT, 16'($urandom), 16'($urandom), 8'($urandom),
                         8'($urandom), produced);
            end
            if (broken) begin
               send_item(rfb_pkg::mode_type'($urandom_range(1, 3)), 16'($urandom),
                         16'($urandom), 8'($urandom), 8'($urandom), produced);
            end
         end else if (pick < 70) begin
            send_item(rfb_pkg::MODE_OK, 16'($urandom), 16'($urandom), 8'($urandom),
                      8'($urandom), produced);
         end else if (pick < 78) begin
            send_item(rfb_pkg::MODE_ERROR, 16'($urandom), 16'($urandom), 8'($urandom),
                      8'($urandom), produced);
         end else if (pick < 86) begin
            send_item(rfb_pkg::MODE_HEARTBEAT, 16'($urandom), 16'($urandom), 8'($urandom),
                      8'($urandom), produced);
         end else if (pick < 97) begin
            // noise: any mode, any field values
            send_item(rfb_pkg::mode_type'($urandom_range(0, 3)), 16'($urandom),
                      16'($urandom), 8'($urandom), 8'($urandom), produced);
         end else if (frame_bytes_due.size() != 0) begin
            // hold off until every pending byte has come out
            req_valid <= 1'b0;
            while (frame_bytes_due.size() != 0) @(posedge clock);
         end
      end
   endtask

   // ---------------- main sequence ----------------

   initial begin
      stim_row_type row;
      int produced;
      int phase;
      logic [8:0] limit_val;
      logic [8:0] type_val;
      logic [8:0] version_val;

      build_directed_rows();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_reg) begin
            write_reg(row.reg_index, row.reg_value);
         end else begin
            send_item(row.mode, row.dev, row.cmd, row.len, row.data, produced);
            if (row.want_count >= 0 && (produced != row.want_count ||
                (produced > 0 && frame_bytes_due[$].refused != row.want_refused))) begin
               bad_checks++;
               $display("%0t: directed row %0d expected %0d bytes refused %0b, got %0d",
                        $time, i, row.want_count, row.want_refused, produced);
            end
         end
      end

      // random phases, each under its own register settings
      for (phase = 0; phase < 6; phase++) begin
         gaps_on     = (phase != 2);
         type_val    = 9'($urandom_range(0, 511));
         version_val = 9'($urandom_range(0, 511));
         case (phase)
            0: begin
               type_val    = 9'h000;
               version_val = 9'h1FF;
               limit_val   = 9'd268;
            end
            1: limit_val = 9'd511;
            2: limit_val = 9'($urandom_range(13, 40));
            3: begin
               type_val    = 9'h1FF;
               version_val = 9'h000;
               limit_val   = 9'd14;
            end
            4: limit_val = 9'($urandom_range(0, 511));
            default: begin
               type_val    = 9'd1;
               version_val = 9'd1;
               limit_val   = 9'd268;
               write_reg(CSR_UNUSED, 9'($urandom_range(0, 511)));
            end
         endcase
         write_reg(rfb_pkg::CSR_RESPONSE_TYPE, type_val);
         write_reg(rfb_pkg::CSR_FRAME_VERSION, version_val);
         write_reg(rfb_pkg::CSR_MAX_FRAME_LEN, limit_val);
         run_frames(items_sent + 56);
      end

      settle();
      if (bad_checks == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Run time limit
   initial begin
      #10ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/rfb_pkg.sv
hw/rtl/rfb_front.sv
hw/rtl/rfb_queue.sv
hw/rtl/rfb_back.sv
hw/rtl/response_frame_builder_crc16_core.sv
test/tb.sv
